>>> sv/rfsc_pkg.sv
// Shared types and constants of the stack calculator.
package rfsc_pkg;

    localparam int unsigned DEPTH_DEFAULT = 64;
    localparam logic [6:0] CAP_RESET = 7'd64;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [5:0] DIV_LAST_STEP = 6'd48;

    typedef enum logic [3:0] {
        ACT_PUSH  = 4'd0,
        ACT_ADD   = 4'd1,
        ACT_SUB   = 4'd2,
        ACT_MUL   = 4'd3,
        ACT_DIV   = 4'd4,
        ACT_NEG   = 4'd5,
        ACT_SWAP  = 4'd6,
        ACT_DUP   = 4'd7,
        ACT_DROP  = 4'd8,
        ACT_CLEAR = 4'd9
    } act_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_FEW_OPS  = 2'd2,
        ST_DIV_ZERO = 2'd3
    } stat_t;

    typedef enum logic [1:0] {
        FOP_ADD = 2'd0,
        FOP_SUB = 2'd1,
        FOP_MUL = 2'd2,
        FOP_DIV = 2'd3
    } fop_t;

    typedef struct packed {
        logic start;
        fop_t op;
    } fpu_req_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_PRE,
        F_DIV,
        F_NORM,
        F_DONE
    } fst_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_SWAP2,
        S_OUT
    } cst_t;

endpackage

>>> sv/rfsc_fpu.sv
// Iterative binary32 add, subtract, multiply and divide unit with round to nearest even.
module rfsc_fpu (
    input  logic                clk,
    input  logic                rst_n,
    input  rfsc_pkg::fpu_req_t  req,
    input  logic [31:0]         a,
    input  logic [31:0]         b,
    output logic                done,
    output logic [31:0]         result
);
    import rfsc_pkg::*;

    fst_t               state_reg, state_next;
    logic               sign_reg, sign_next;
    logic signed [11:0] e_reg, e_next;
    logic [49:0]        m_reg, m_next;
    logic [23:0]        ma_reg, ma_next;
    logic [23:0]        mb_reg, mb_next;
    logic [24:0]        rem_reg, rem_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [31:0]        res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sign_reg <= sign_next;
        e_reg    <= e_next;
        m_reg    <= m_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        logic        sa, sb;
        logic [7:0]  xa, xb, xea, xeb;
        logic [22:0] fa, fb;
        logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic [23:0] mant_a, mant_b;
        logic        a_big;
        logic [7:0]  dshift, e_big;
        logic        s_big;
        logic [49:0] m_big, m_small, m_sh, sum;
        logic        lost;
        logic [47:0] prod;
        logic        ge;
        logic [24:0] rdiff;
        logic [7:0]  ef;
        logic [30:0] packed_r;
        logic        inc;

        state_next = state_reg;
        sign_next  = sign_reg;
        e_next     = e_reg;
        m_next     = m_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;

        sa = a[31];
        sb = (req.op == FOP_SUB) ? ~b[31] : b[31];
        xa = a[30:23];
        xb = b[30:23];
        fa = a[22:0];
        fb = b[22:0];
        a_nan  = (xa == 8'hFF) && (fa != '0);
        b_nan  = (xb == 8'hFF) && (fb != '0);
        a_inf  = (xa == 8'hFF) && (fa == '0);
        b_inf  = (xb == 8'hFF) && (fb == '0);
        a_zero = (xa == 8'h00) && (fa == '0);
        b_zero = (xb == 8'h00) && (fb == '0);
        xea    = (xa == 8'h00) ? 8'd1 : xa;
        xeb    = (xb == 8'h00) ? 8'd1 : xb;
        mant_a = {xa != 8'h00, fa};
        mant_b = {xb != 8'h00, fb};

        // Alignment for add and subtract: the operand of larger magnitude stays put.
        a_big   = a[30:0] >= b[30:0];
        e_big   = a_big ? xea : xeb;
        s_big   = a_big ? sa : sb;
        dshift  = a_big ? (xea - xeb) : (xeb - xea);
        m_big   = {1'b0, (a_big ? mant_a : mant_b), 25'b0};
        m_small = {1'b0, (a_big ? mant_b : mant_a), 25'b0};
        m_sh    = m_small >> dshift;
        lost    = (m_sh << dshift) != m_small;
        m_sh    = m_sh | {49'b0, lost};
        sum     = (sa == sb) ? (m_big + m_sh) : (m_big - m_sh);

        prod = mant_a * mant_b;

        ge    = rem_reg >= {1'b0, mb_reg};
        rdiff = ge ? (rem_reg - {1'b0, mb_reg}) : rem_reg;

        ef       = m_reg[48] ? e_reg[7:0] : 8'd0;
        inc      = m_reg[24] & ((|m_reg[23:0]) | m_reg[25]);
        packed_r = {ef, m_reg[47:25]} + {30'b0, inc};

        unique case (state_reg)
            F_IDLE:
            begin
                if (req.start)
                begin
                    state_next = F_DONE;
                    unique case (req.op)
                        FOP_ADD, FOP_SUB:
                        begin
                            if (a_nan || b_nan || (a_inf && b_inf && (sa != sb)))
                                res_next = CANON_NAN;
                            else if (a_inf)
                                res_next = {sa, 8'hFF, 23'b0};
                            else if (b_inf)
                                res_next = {sb, 8'hFF, 23'b0};
                            else if (a_zero && b_zero)
                                res_next = {sa & sb, 31'b0};
                            else if (a_zero)
                                res_next = {sb, b[30:0]};
                            else if (b_zero)
                                res_next = a;
                            else if (sum == '0)
                                res_next = 32'b0;
                            else
                            begin
                                sign_next  = s_big;
                                e_next     = $signed({4'b0, e_big});
                                m_next     = sum;
                                state_next = F_NORM;
                            end
                        end
                        FOP_MUL:
                        begin
                            if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
                                res_next = CANON_NAN;
                            else if (a_inf || b_inf)
                                res_next = {sa ^ sb, 8'hFF, 23'b0};
                            else if (a_zero || b_zero)
                                res_next = {sa ^ sb, 31'b0};
                            else
                            begin
                                sign_next  = sa ^ sb;
                                e_next     = $signed({4'b0, xea}) + $signed({4'b0, xeb})
                                             - 12'sd125;
                                m_next     = {2'b0, prod};
                                state_next = F_NORM;
                            end
                        end
                        FOP_DIV:
                        begin
                            if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero))
                                res_next = CANON_NAN;
                            else if (a_inf || b_zero)
                                res_next = {sa ^ sb, 8'hFF, 23'b0};
                            else if (a_zero || b_inf)
                                res_next = {sa ^ sb, 31'b0};
                            else
                            begin
                                sign_next  = sa ^ sb;
                                e_next     = $signed({4'b0, xea}) - $signed({4'b0, xeb})
                                             + 12'sd127;
                                ma_next    = mant_a;
                                mb_next    = mant_b;
                                state_next = F_PRE;
                            end
                        end
                        default:
                        begin
                            res_next = CANON_NAN;
                        end
                    endcase
                end
            end
            F_PRE:
            begin
                // Subnormal operands are shifted up one bit a cycle.
                if (ma_reg[23] && mb_reg[23])
                begin
                    rem_next   = {1'b0, ma_reg};
                    m_next     = '0;
                    cnt_next   = '0;
                    state_next = F_DIV;
                end
                else
                begin
                    if (!ma_reg[23])
                    begin
                        ma_next = {ma_reg[22:0], 1'b0};
                    end
                    if (!mb_reg[23])
                    begin
                        mb_next = {mb_reg[22:0], 1'b0};
                    end
                    e_next = e_reg - (ma_reg[23] ? 12'sd0 : 12'sd1)
                                   + (mb_reg[23] ? 12'sd0 : 12'sd1);
                end
            end
            F_DIV:
            begin
                m_next   = {m_reg[48:0], ge};
                rem_next = {rdiff[23:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST_STEP)
                begin
                    m_next[0]  = ge | (rdiff != '0);
                    state_next = F_NORM;
                end
            end
            F_NORM:
            begin
                if (m_reg[49])
                begin
                    m_next = {1'b0, m_reg[49:2], m_reg[1] | m_reg[0]};
                    e_next = e_reg + 12'sd1;
                end
                else if (e_reg < 12'sd1)
                begin
                    if (m_reg[49:1] == '0)
                    begin
                        e_next = 12'sd1;
                    end
                    else
                    begin
                        m_next = {1'b0, m_reg[49:2], m_reg[1] | m_reg[0]};
                        e_next = e_reg + 12'sd1;
                    end
                end
                else if (!m_reg[48] && (e_reg > 12'sd1))
                begin
                    m_next = {m_reg[48:0], 1'b0};
                    e_next = e_reg - 12'sd1;
                end
                else
                begin
                    if (e_reg >= 12'sd255)
                        res_next = {sign_reg, 8'hFF, 23'b0};
                    else
                        res_next = {sign_reg, packed_r};
                    state_next = F_DONE;
                end
            end
            F_DONE:
            begin
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign done   = (state_reg == F_DONE);
    assign result = res_reg;

endmodule

>>> sv/rpn_float_stack_calculator_unit.sv
// Top level of the RPN stack calculator on binary32 values.
// Each command transfer is handled one at a time: the command port stalls from the transfer
// until its result has been transferred out. Push, negate, duplicate, drop, clear and unknown
// codes pass through the states S_EXEC and S_OUT; swap adds S_SWAP2, because the single
// write port of the stack memory needs two writes. Add, subtract, multiply and divide go
// through one shared iterative float unit: add and subtract are paced by the one-bit-a-cycle
// normalizing shifter after cancellation, multiply by the same shifter for subnormal results,
// divide by the restoring divider that makes one quotient bit a cycle (49 bits) plus subnormal
// pre-shifts and the one-bit-a-cycle denormalizing shifts of results that fall below the
// normal range. The stack lives in a memory of DEPTH words with one write and one registered
// read port; the top entry is also kept in a register so it can be shown without a read. The
// configuration register capacity_in_use limits the number of entries (0 acts as 1, values
// above DEPTH act as DEPTH); the user must write it only while the block is idle, which the
// block does not enforce; cfg_ready is always high. Every result carries a status, the depth
// and the top entry (zero when the stack is empty).
module rpn_float_stack_calculator_unit #(
    parameter int unsigned DEPTH = rfsc_pkg::DEPTH_DEFAULT,
    parameter int unsigned DW    = $clog2(DEPTH + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  logic [3:0]    action,
    input  logic [31:0]   operand_value,
    output logic          res_valid,
    input  logic          res_stall,
    output logic [1:0]    status,
    output logic [DW-1:0] depth,
    output logic [31:0]   top_value,
    output logic          top_valid,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [6:0]    capacity_in_use
);
    import rfsc_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = (DW > 7) ? DW : 7;

    cst_t          state_reg, state_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [31:0]   top_reg, top_next;
    stat_t         status_reg, status_next;
    act_t          cmd_reg, cmd_next;
    logic [31:0]   val_reg, val_next;
    logic [31:0]   swap_reg, swap_next;
    logic [6:0]    cap_reg;

    // Stack memory, one write and one registered read per cycle.
    logic [31:0]   mem [DEPTH];
    logic [31:0]   rd_data_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [AW-1:0] rd_addr;

    logic [DW-1:0] dm1, dm2;
    logic [CW-1:0] d_ext, cap_ext;
    logic          full;
    logic          accept;

    fpu_req_t      fpu_req;
    logic          fpu_done;
    logic [31:0]   fpu_result;

    rfsc_fpu u_fpu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (fpu_req),
        .a      (rd_data_reg),
        .b      (top_reg),
        .done   (fpu_done),
        .result (fpu_result)
    );

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign dm1     = depth_reg - DW'(1);
    assign dm2     = depth_reg - DW'(2);
    assign rd_addr = dm2[AW-1:0];

    // The stack counts as full at the memory size or at the configured capacity,
    // where a capacity of zero counts as one.
    assign d_ext   = CW'(depth_reg);
    assign cap_ext = (cap_reg == '0) ? CW'(1) : CW'(cap_reg);
    assign full    = (d_ext >= CW'(DEPTH)) || (d_ext >= cap_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            depth_reg <= '0;
            cap_reg   <= CAP_RESET;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= capacity_in_use;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        status_reg <= status_next;
        cmd_reg    <= cmd_next;
        val_reg    <= val_next;
        swap_reg   <= swap_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next  = state_reg;
        depth_next  = depth_reg;
        top_next    = top_reg;
        status_next = status_reg;
        cmd_next    = cmd_reg;
        val_next    = val_reg;
        swap_next   = swap_reg;
        wr_en       = 1'b0;
        wr_addr     = depth_reg[AW-1:0];
        wr_data     = top_reg;
        fpu_req     = '{start: 1'b0, op: FOP_ADD};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = act_t'(action);
                    val_next   = operand_value;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // The second entry from the top has been read by now.
                status_next = ST_OK;
                state_next  = S_OUT;
                unique case (cmd_reg)
                    ACT_PUSH:
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = depth_reg[AW-1:0];
                            wr_data    = val_reg;
                            top_next   = val_reg;
                            depth_next = depth_reg + DW'(1);
                        end
                    end
                    ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV:
                    begin
                        if (depth_reg < DW'(2))
                        begin
                            status_next = ST_FEW_OPS;
                        end
                        else if ((cmd_reg == ACT_DIV) && (top_reg[30:0] == '0))
                        begin
                            status_next = ST_DIV_ZERO;
                        end
                        else
                        begin
                            fpu_req.start = 1'b1;
                            priority case (cmd_reg)
                                ACT_ADD: fpu_req.op = FOP_ADD;
                                ACT_SUB: fpu_req.op = FOP_SUB;
                                ACT_MUL: fpu_req.op = FOP_MUL;
                                default: fpu_req.op = FOP_DIV;
                            endcase
                            state_next = S_WAIT;
                        end
                    end
                    ACT_NEG:
                    begin
                        if (depth_reg == '0)
                        begin
                            status_next = ST_FEW_OPS;
                        end
                        else
                        begin
                            wr_en    = 1'b1;
                            wr_addr  = dm1[AW-1:0];
                            wr_data  = {~top_reg[31], top_reg[30:0]};
                            top_next = {~top_reg[31], top_reg[30:0]};
                        end
                    end
                    ACT_SWAP:
                    begin
                        if (depth_reg < DW'(2))
                        begin
                            status_next = ST_FEW_OPS;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = dm1[AW-1:0];
                            wr_data    = rd_data_reg;
                            top_next   = rd_data_reg;
                            swap_next  = top_reg;
                            state_next = S_SWAP2;
                        end
                    end
                    ACT_DUP:
                    begin
                        if (depth_reg == '0)
                        begin
                            status_next = ST_FEW_OPS;
                        end
                        else if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = depth_reg[AW-1:0];
                            wr_data    = top_reg;
                            depth_next = depth_reg + DW'(1);
                        end
                    end
                    ACT_DROP:
                    begin
                        if (depth_reg == '0)
                        begin
                            status_next = ST_FEW_OPS;
                        end
                        else
                        begin
                            top_next   = rd_data_reg;
                            depth_next = dm1;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        depth_next = '0;
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_WAIT:
            begin
                if (fpu_done)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = dm2[AW-1:0];
                    wr_data    = fpu_result;
                    top_next   = fpu_result;
                    depth_next = dm1;
                    state_next = S_OUT;
                end
            end
            S_SWAP2:
            begin
                wr_en      = 1'b1;
                wr_addr    = dm2[AW-1:0];
                wr_data    = swap_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!res_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The result is held in registers for as long as the result transfer is stalled.
    assign res_valid = (state_reg == S_OUT);
    assign status    = status_reg;
    assign depth     = depth_reg;
    assign top_valid = (depth_reg != '0);
    assign top_value = (depth_reg != '0) ? top_reg : 32'b0;

endmodule

>>> sim/rpn_float_stack_calculator_unit_test.sv
// Self-checking testbench of the RPN float stack calculator, with its own stack and float predictor.
module rpn_float_stack_calculator_unit_test;
    import rfsc_pkg::*;

    // Expected content of one result transfer.
    typedef struct {
        logic [1:0]  status;
        logic [6:0]  depth;
        logic [31:0] top_value;
        logic        top_valid;
    } calc_result_t;

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    logic [3:0]  action;
    logic [31:0] operand_value;
    logic        res_valid;
    logic        res_stall;
    logic [1:0]  status;
    logic [6:0]  depth;
    logic [31:0] top_value;
    logic        top_valid;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  capacity_in_use;

    // Predictor state: a private copy of the stack, its depth and the capacity register.
    logic [31:0]  shadow_stack [64];
    int unsigned  shadow_depth;
    logic [6:0]   shadow_capacity;
    calc_result_t pending_results [$];

    int unsigned  mismatch_count;
    int unsigned  cycle_count;
    int unsigned  burst_left;
    bit           sender_gaps_on;
    int unsigned  stall_phase;
    int unsigned  stall_mode;

    rpn_float_stack_calculator_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .action          (action),
        .operand_value   (operand_value),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .status          (status),
        .depth           (depth),
        .top_value       (top_value),
        .top_valid       (top_valid),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .capacity_in_use (capacity_in_use)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The run is cut off far above the slowest legal run: about 1300 commands, each at most a
    // divide plus sender gaps and long receiver stalls.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Widens a binary32 pattern to a binary64 pattern exactly, subnormals included.
    function automatic logic [63:0] single_to_double(input logic [31:0] f);
        logic [23:0] mant;
        int          expo;
        mant = {1'b0, f[22:0]};
        if (f[30:23] == 8'hFF)
            return {f[31], 11'h7FF, f[22:0], 29'd0};
        if (f[30:23] == 8'd0)
        begin
            if (mant == 24'd0)
                return {f[31], 63'd0};
            expo = -126;
            while (!mant[23])
            begin
                mant = mant << 1;
                expo = expo - 1;
            end
            return {f[31], 11'(expo + 1023), mant[22:0], 29'd0};
        end
        return {f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'd0};
    endfunction

    // Rounds a binary64 pattern to binary32 with round-to-nearest-even. Going through binary64
    // is safe for the four basic operations because 53 >= 2 * 24 + 2 bits.
    function automatic logic [31:0] double_to_single(input logic [63:0] d);
        logic [63:0] sig;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] half;
        int          fexp;
        int          shift;
        if (d[62:52] == 11'h7FF)
            return (d[51:0] != 52'd0) ? CANON_NAN : {d[63], 8'hFF, 23'd0};
        if (d[62:52] == 11'd0)
            return {d[63], 31'd0};
        sig   = {11'd0, 1'b1, d[51:0]};
        fexp  = int'(d[62:52]) - 1023 + 127;
        shift = (fexp >= 1) ? 29 : 29 + 1 - fexp;
        if (shift > 60)
            shift = 60;
        quo  = sig >> shift;
        rem  = sig & ((64'd1 << shift) - 64'd1);
        half = 64'd1 << (shift - 1);
        if (rem > half || (rem == half && quo[0]))
            quo = quo + 64'd1;
        if (fexp < 1)
            return {d[63], quo[30:0]};
        if (quo == (64'd1 << 24))
        begin
            quo  = quo >> 1;
            fexp = fexp + 1;
        end
        if (fexp >= 255)
            return {d[63], 8'hFF, 23'd0};
        return {d[63], fexp[7:0], quo[22:0]};
    endfunction

    function automatic logic [31:0] float_result(input logic [3:0] op, input logic [31:0] lhs,
                                                 input logic [31:0] rhs);
        real x;
        real y;
        real r;
        x = $bitstoreal(single_to_double(lhs));
        y = $bitstoreal(single_to_double(rhs));
        case (op)
            ACT_ADD: r = x + y;
            ACT_SUB: r = x - y;
            ACT_MUL: r = x * y;
            default: r = x / y;
        endcase
        return double_to_single($realtobits(r));
    endfunction

    // Applies one accepted command to the private stack and queues the result it must produce.
    task automatic apply_command(input logic [3:0] act, input logic [31:0] val);
        calc_result_t exp_res;
        int unsigned  cap;
        int unsigned  d;
        bit           full;
        logic [31:0]  tmp;
        stat_t        st;
        d   = shadow_depth;
        st  = ST_OK;
        cap = (shadow_capacity == 7'd0) ? 1 : (shadow_capacity > 7'd64) ? 64 : shadow_capacity;
        full = (d >= cap) || (d >= 64);
        case (act)
            ACT_PUSH:
                if (full)
                    st = ST_FULL;
                else
                begin
                    shadow_stack[d] = val;
                    d = d + 1;
                end
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV:
                if (d < 2)
                    st = ST_FEW_OPS;
                else if (act == ACT_DIV && shadow_stack[d-1][30:0] == 31'd0)
                    st = ST_DIV_ZERO;
                else
                begin
                    shadow_stack[d-2] = float_result(act, shadow_stack[d-2], shadow_stack[d-1]);
                    d = d - 1;
                end
            ACT_NEG:
                if (d < 1)
                    st = ST_FEW_OPS;
                else
                    shadow_stack[d-1][31] = ~shadow_stack[d-1][31];
            ACT_SWAP:
                if (d < 2)
                    st = ST_FEW_OPS;
                else
                begin
                    tmp               = shadow_stack[d-1];
                    shadow_stack[d-1] = shadow_stack[d-2];
                    shadow_stack[d-2] = tmp;
                end
            ACT_DUP:
                if (d < 1)
                    st = ST_FEW_OPS;
                else if (full)
                    st = ST_FULL;
                else
                begin
                    shadow_stack[d] = shadow_stack[d-1];
                    d = d + 1;
                end
            ACT_DROP:
                if (d < 1)
                    st = ST_FEW_OPS;
                else
                    d = d - 1;
            ACT_CLEAR:
                d = 0;
            default:
                ;
        endcase
        shadow_depth      = d;
        exp_res.status    = st;
        exp_res.depth     = 7'(d);
        exp_res.top_value = (d > 0) ? shadow_stack[d-1] : 32'd0;
        exp_res.top_valid = (d > 0);
        pending_results.push_back(exp_res);
    endtask

    // Sends one command transfer. It is entered and left at a falling edge; the valid stays
    // high on return so that back-to-back transfers need no second assignment in one step.
    task automatic send_cmd(input logic [3:0] act, input logic [31:0] val);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap        = sender_gaps_on ? $urandom_range(0, 6) : 0;
            burst_left = $urandom_range(1, 10);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        cmd_valid     <= 1'b1;
        action        <= act;
        operand_value <= val;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        apply_command(act, val);
        burst_left = burst_left - 1;
        @(negedge clk);
    endtask

    // Lowers the valid and waits until every result is in and the block has settled.
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Writes the capacity register while the block is idle.
    task automatic write_capacity(input logic [6:0] value);
        wait_drained();
        cfg_valid       <= 1'b1;
        capacity_in_use <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_capacity = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Float patterns biased toward special values, close exponents and subnormals.
    function automatic logic [31:0] pick_float();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: case ($urandom_range(0, 7))
                   0: v = 32'h0000_0000;
                   1: v = 32'h8000_0000;
                   2: v = 32'h7F80_0000;
                   3: v = 32'hFF80_0000;
                   4: v = {v[31], 8'hFF, 1'b1, v[21:0]};
                   5: v = {v[31], 31'h7F7F_FFFF};
                   6: v = {v[31], 31'd1};
                   default: v = 32'h3F80_0000;
               endcase
            1, 2: v = {v[31], 8'd0, v[22:0]};
            3: v = {v[31], 8'(8'd120 + v[25:23]), v[22:0]} & 32'hFFFF_F000;
            4: if (shadow_depth > 0)
                   v = shadow_stack[shadow_depth-1] ^ {28'd0, v[3:0]};
            5: v = {v[31], 8'(8'd1 + v[25:23]), v[22:0]};
            6: v = {v[31], 8'(8'd245 + v[25:23]), v[22:0]};
            default: v = {v[31], 8'(8'd110 + v[27:23]), v[22:0]};
        endcase
        return v;
    endfunction

    // Reset state: every operation but push on an empty stack, and the unknown codes.
    task automatic test_empty_stack();
        logic [4:0] code;
        for (code = 5'd1; code < 5'd16; code = code + 5'd1)
            send_cmd(code[3:0], 32'hFFFF_FFFF);
    endtask

    // Extremes of the pushed value, then every operation on them.
    task automatic test_operations();
        send_cmd(ACT_PUSH, 32'hFFFF_FFFF);
        send_cmd(ACT_PUSH, 32'h0000_0000);
        send_cmd(ACT_DIV, 32'd0);
        send_cmd(ACT_NEG, 32'd0);
        send_cmd(ACT_DIV, 32'd0);
        send_cmd(ACT_NEG, 32'd0);
        send_cmd(ACT_SWAP, 32'd0);
        send_cmd(ACT_DROP, 32'd0);
        send_cmd(ACT_PUSH, 32'h7F80_0000);
        send_cmd(ACT_DUP, 32'd0);
        send_cmd(ACT_SUB, 32'd0);
        send_cmd(ACT_PUSH, 32'h4040_0000);
        send_cmd(ACT_PUSH, 32'h0000_0001);
        send_cmd(ACT_MUL, 32'd0);
        send_cmd(ACT_ADD, 32'd0);
        send_cmd(ACT_PUSH, 32'h7F7F_FFFF);
        send_cmd(ACT_DUP, 32'd0);
        send_cmd(ACT_ADD, 32'd0);
        send_cmd(ACT_CLEAR, 32'd0);
    endtask

    // Capacity at its extremes, zero acting as one, and a capacity lowered below the depth.
    task automatic test_capacity();
        write_capacity(7'd0);
        send_cmd(ACT_PUSH, 32'h3F80_0000);
        send_cmd(ACT_PUSH, 32'h4000_0000);
        send_cmd(ACT_DUP, 32'd0);
        write_capacity(7'd127);
        repeat (66) send_cmd(ACT_DUP, 32'd0);
        send_cmd(ACT_PUSH, 32'h4000_0000);
        write_capacity(7'd3);
        send_cmd(ACT_DROP, 32'd0);
        send_cmd(ACT_PUSH, 32'h4000_0000);
        repeat (62) send_cmd(ACT_DROP, 32'd0);
        send_cmd(ACT_PUSH, 32'h4040_0000);
        send_cmd(ACT_DUP, 32'd0);
        send_cmd(ACT_CLEAR, 32'd0);
        write_capacity(7'd64);
    endtask

    // Random commands, mostly well-formed: pushes keep operands available for arithmetic.
    task automatic test_random(input int unsigned count);
        int unsigned n;
        int unsigned pick;
        logic [3:0]  act;
        for (n = 0; n < count; n = n + 1)
        begin
            pick = $urandom_range(0, 99);
            if (shadow_depth < 2 && pick < 60)
                act = ACT_PUSH;
            else if (pick < 30)
                act = ACT_PUSH;
            else if (pick < 70)
                act = 4'($urandom_range(ACT_ADD, ACT_DIV));
            else if (pick < 95)
                act = 4'($urandom_range(ACT_NEG, ACT_CLEAR));
            else if (pick < 97)
                act = 4'($urandom_range(10, 15));
            else
                act = ACT_CLEAR;
            send_cmd(act, pick_float());
        end
    endtask

    // Receiver stall pattern: phases of no stall, light stall and long stall runs.
    always @(negedge clk)
    begin
        if (stall_phase == 0)
        begin
            stall_mode  <= $urandom_range(0, 2);
            stall_phase <= $urandom_range(20, 200);
        end
        else
            stall_phase <= stall_phase - 1;
        case (stall_mode)
            0: res_stall <= 1'b0;
            1: res_stall <= ($urandom_range(0, 3) == 0);
            default: res_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    // Compares each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        calc_result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected: status %0d depth %0d top %h",
                         $time, status, depth, top_value);
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status || depth !== want.depth ||
                    top_value !== want.top_value || top_valid !== want.top_valid)
                begin
                    $display("%0t: expected status %0d depth %0d top %h valid %b", $time,
                             want.status, want.depth, want.top_value, want.top_valid);
                    $display("%0t: actual   status %0d depth %0d top %h valid %b", $time,
                             status, depth, top_value, top_valid);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cmd_valid       = 1'b0;
        action          = 4'd0;
        operand_value   = 32'd0;
        res_stall       = 1'b0;
        cfg_valid       = 1'b0;
        capacity_in_use = 7'd0;
        mismatch_count  = 0;
        cycle_count     = 0;
        burst_left      = 0;
        sender_gaps_on  = 1'b1;
        stall_phase     = 0;
        stall_mode      = 0;
        shadow_depth    = 0;
        shadow_capacity = CAP_RESET;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_stack();
        test_operations();
        test_capacity();
        test_random(400);
        write_capacity(7'($urandom_range(1, 8)));
        sender_gaps_on = 1'b0;
        test_random(300);
        write_capacity(7'($urandom_range(9, 127)));
        sender_gaps_on = 1'b1;
        test_random(300);
        write_capacity(7'd64);
        test_random(80);

        wait_drained();
        repeat (120) @(negedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
sv/rfsc_pkg.sv
sv/rfsc_fpu.sv
sv/rpn_float_stack_calculator_unit.sv
sim/rpn_float_stack_calculator_unit_test.sv
